[hw/rtl/sml_pkg.sv]
package sml_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PADDR_W = 3;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_SECOND = 2'd1;
  localparam logic [1:0] MODE_MERGE = 2'd2;

  localparam logic REG_DEDUP = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic signed [DATA_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] merged_value;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic start;
    logic step;
    logic finish;
  } sml_cmd_t;

  typedef struct packed {
    logic first_full;
    logic second_full;
    logic have_more;
    logic slot_free;
  } sml_status_t;

endpackage

[hw/rtl/sml_ram.sv]
module sml_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/sml_ctrl.sv]
module sml_ctrl import sml_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [1:0]  mode_i,
  output logic        in_ready_o,
  input  sml_status_t status_i,
  output sml_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (mode_i == MODE_MERGE)) begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (status_i.slot_free && !status_i.have_more) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (mode_i)
            MODE_FIRST:  cmd_o.load_first = !status_i.first_full;
            MODE_SECOND: cmd_o.load_second = !status_i.second_full;
            MODE_MERGE:  cmd_o.start = 1'b1;
            default:     cmd_o = '0;
          endcase
        end
      end
      ST_MERGE: begin
        if (status_i.slot_free) begin
          cmd_o.step = status_i.have_more;
          cmd_o.finish = !status_i.have_more;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

[hw/rtl/sml_datapath.sv]
module sml_datapath import sml_pkg::*; #(
  parameter int unsigned ListDepth = LIST_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sml_cmd_t    cmd_i,
  input  logic [DATA_W-1:0] load_value_i,
  input  logic        dedup_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output out_item_t   out_item_o,
  output sml_status_t status_o
);

  localparam int unsigned CW = $clog2(ListDepth + 1);
  localparam int unsigned AW = (ListDepth > 1) ? $clog2(ListDepth) : 1;

  logic [CW-1:0] fc_q, fc_d, sc_q, sc_d, i_q, i_d, j_q, j_d;
  logic [DATA_W-1:0] first_rdata, second_rdata, pick;
  logic [DATA_W-1:0] pend_value_q, pend_value_d;
  logic pend_valid_q, pend_valid_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;
  logic take_first, dup, slot_free;

  sml_ram #(.Width(DATA_W), .Depth(ListDepth), .AddrW(AW)) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_first),
    .waddr_i (fc_q[AW-1:0]),
    .wdata_i (load_value_i),
    .raddr_i (i_d[AW-1:0]),
    .rdata_o (first_rdata)
  );

  sml_ram #(.Width(DATA_W), .Depth(ListDepth), .AddrW(AW)) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_second),
    .waddr_i (sc_q[AW-1:0]),
    .wdata_i (load_value_i),
    .raddr_i (j_d[AW-1:0]),
    .rdata_o (second_rdata)
  );

  assign slot_free = !out_valid_q || out_ready_i;
  assign take_first = (i_q < fc_q) &&
                      ((j_q >= sc_q) || ($signed(first_rdata) < $signed(second_rdata)));
  assign pick = take_first ? first_rdata : second_rdata;
  assign dup = dedup_i && pend_valid_q && (pick == pend_value_q);

  always_comb begin
    fc_d = fc_q;
    sc_d = sc_q;
    i_d = i_q;
    j_d = j_q;
    pend_valid_d = pend_valid_q;
    pend_value_d = pend_value_q;
    out_item_d = out_item_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load_first) begin
      fc_d = fc_q + CW'(1);
    end
    if (cmd_i.load_second) begin
      sc_d = sc_q + CW'(1);
    end
    if (cmd_i.start) begin
      i_d = '0;
      j_d = '0;
      pend_valid_d = 1'b0;
    end
    if (cmd_i.step) begin
      if (take_first) begin
        i_d = i_q + CW'(1);
      end else begin
        j_d = j_q + CW'(1);
      end
      if (!dup) begin
        if (pend_valid_q) begin
          out_valid_d = 1'b1;
          out_item_d.merged_value = pend_value_q;
          out_item_d.last = 1'b0;
        end
        pend_valid_d = 1'b1;
        pend_value_d = pick;
      end
    end
    if (cmd_i.finish) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_item_d.merged_value = pend_value_q;
        out_item_d.last = 1'b1;
      end
      pend_valid_d = 1'b0;
      fc_d = '0;
      sc_d = '0;
      i_d = '0;
      j_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= '0;
      sc_q <= '0;
      i_q <= '0;
      j_q <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fc_q <= fc_d;
      sc_q <= sc_d;
      i_q <= i_d;
      j_q <= j_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_value_q <= pend_value_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_item_q;

  assign status_o.first_full = (fc_q == CW'(ListDepth));
  assign status_o.second_full = (sc_q == CW'(ListDepth));
  assign status_o.have_more = (i_q < fc_q) || (j_q < sc_q);
  assign status_o.slot_free = slot_free;

`ifndef SYNTH
  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fc_q <= CW'(ListDepth)) && (sc_q <= CW'(ListDepth)))
    else $error("list count above depth");

  a_heads_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (i_q <= fc_q) && (j_q <= sc_q))
    else $error("merge index beyond list count");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (fc_q == '0) && (sc_q == '0) && !pend_valid_q)
    else $error("lists not emptied after merge");

  a_step_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step || cmd_i.finish) |-> slot_free)
    else $error("merge advanced into a held output");
`endif

endmodule

[hw/rtl/sorted_list_merge.sv]
// Append items (mode 0 or 1) are written while idle; a full list ignores the append.
// A merge starts, steps once per element through the single compare of both list heads,
// then flushes the final item; each step waits for a free output slot.
// Results appear at one per cycle while out_ready_i is high, save dropped duplicates.
// rst_ni clears both list counts, the merge state, the output and dedup_enable.
module sorted_list_merge import sml_pkg::*; #(
  parameter int unsigned ListDepth = LIST_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic dedup_q, dedup_d;
  sml_cmd_t cmd;
  sml_status_t status;

  assign pready = 1'b1;

  always_comb begin
    dedup_d = dedup_q;
    if (psel && penable && pwrite && (paddr[2] == REG_DEDUP)) begin
      dedup_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dedup_q <= 1'b0;
    end else begin
      dedup_q <= dedup_d;
    end
  end

  assign prdata = (paddr[2] == REG_DEDUP) ? {31'b0, dedup_q} : 32'b0;

  sml_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (in_item_i.mode),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sml_datapath #(.ListDepth(ListDepth)) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .load_value_i (in_item_i.item_value),
    .dedup_i      (dedup_q),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_item_o   (out_item_o),
    .status_o     (status)
  );

endmodule
